// ===== src/sfr_pkg.sv =====
package sfr_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAG        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_FLAG    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ESC_ESCAPE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SEQ0   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_SEQ1   = 3'd6;

    // Reset values of the configuration registers.
    localparam logic [7:0] RST_FLAG       = 8'h7E;
    localparam logic [7:0] RST_ADDRESS    = 8'h03;
    localparam logic [7:0] RST_ESCAPE     = 8'h7D;
    localparam logic [7:0] RST_ESC_FLAG   = 8'h5E;
    localparam logic [7:0] RST_ESC_ESCAPE = 8'h5D;
    localparam logic [7:0] RST_CTRL_SEQ0  = 8'h00;
    localparam logic [7:0] RST_CTRL_SEQ1  = 8'h40;

    // Result item kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // End of frame verdicts.
    localparam logic [1:0] VERDICT_NEW       = 2'd0;
    localparam logic [1:0] VERDICT_DUPLICATE = 2'd1;
    localparam logic [1:0] VERDICT_CHECK_ERR = 2'd2;
    localparam logic [1:0] VERDICT_BAD_ESC   = 2'd3;

    typedef struct packed {
        logic [7:0] flag_byte;
        logic [7:0] address_byte;
        logic [7:0] escape_byte;
        logic [7:0] escaped_flag_code;
        logic [7:0] escaped_escape_code;
        logic [7:0] info_control_seq0;
        logic [7:0] info_control_seq1;
    } t_cfg;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] payload_byte;
        logic [1:0] verdict;
        logic       reply_wanted;
        logic       reply_is_reject;
        logic       reply_seq;
    } t_result;

endpackage

// ===== src/sfr_rx_if.sv =====
interface sfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== src/sfr_res_if.sv =====
interface sfr_res_if;
    logic       valid;
    logic       ready;
    logic       item_kind;
    logic [7:0] payload_byte;
    logic [1:0] verdict;
    logic       reply_wanted;
    logic       reply_is_reject;
    logic       reply_seq;

    modport source (
        output valid, output item_kind, output payload_byte, output verdict,
        output reply_wanted, output reply_is_reject, output reply_seq,
        input ready
    );
    modport sink (
        input valid, input item_kind, input payload_byte, input verdict,
        input reply_wanted, input reply_is_reject, input reply_seq,
        output ready
    );
endinterface

// ===== src/sfr_cfg_regs.sv =====
module sfr_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                   i_cfg_data,
    output sfr_pkg::t_cfg                o_cfg
);

    sfr_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.flag_byte           <= sfr_pkg::RST_FLAG;
            r_cfg.address_byte        <= sfr_pkg::RST_ADDRESS;
            r_cfg.escape_byte         <= sfr_pkg::RST_ESCAPE;
            r_cfg.escaped_flag_code   <= sfr_pkg::RST_ESC_FLAG;
            r_cfg.escaped_escape_code <= sfr_pkg::RST_ESC_ESCAPE;
            r_cfg.info_control_seq0   <= sfr_pkg::RST_CTRL_SEQ0;
            r_cfg.info_control_seq1   <= sfr_pkg::RST_CTRL_SEQ1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                sfr_pkg::CFG_FLAG:       r_cfg.flag_byte           <= i_cfg_data;
                sfr_pkg::CFG_ADDRESS:    r_cfg.address_byte        <= i_cfg_data;
                sfr_pkg::CFG_ESCAPE:     r_cfg.escape_byte         <= i_cfg_data;
                sfr_pkg::CFG_ESC_FLAG:   r_cfg.escaped_flag_code   <= i_cfg_data;
                sfr_pkg::CFG_ESC_ESCAPE: r_cfg.escaped_escape_code <= i_cfg_data;
                sfr_pkg::CFG_CTRL_SEQ0:  r_cfg.info_control_seq0   <= i_cfg_data;
                sfr_pkg::CFG_CTRL_SEQ1:  r_cfg.info_control_seq1   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/sfr_parser.sv =====
module sfr_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sfr_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  logic [7:0]       i_byte,
    output logic             o_ready,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output sfr_pkg::t_result o_res
);

    typedef enum logic [2:0] {
        ST_HUNT = 3'd0,
        ST_ADDR = 3'd1,
        ST_CTRL = 3'd2,
        ST_HCHK = 3'd3,
        ST_DATA = 3'd4,
        ST_ESC  = 3'd5
    } t_state;

    t_state           r_state, n_state;
    logic [7:0]       r_held, n_held;
    logic             r_held_valid, n_held_valid;
    logic [7:0]       r_xor, n_xor;
    logic             r_frame_seq, n_frame_seq;
    logic             r_expected_seq, n_expected_seq;
    logic             r_data_seen, n_data_seen;
    logic             r_res_valid;
    sfr_pkg::t_result r_res, n_res;
    logic             n_emit;
    logic             w_proc;

    // The result register is free when empty or being taken this cycle.
    assign o_ready = !r_res_valid || i_res_ready;
    assign w_proc  = i_valid && o_ready;

    always_comb begin
        logic       take;
        logic [7:0] data;
        logic [7:0] ctrl;
        logic       ok;

        take           = 1'b0;
        data           = i_byte;
        ctrl           = r_frame_seq ? i_cfg.info_control_seq1 : i_cfg.info_control_seq0;
        ok             = 1'b0;
        n_state        = r_state;
        n_held         = r_held;
        n_held_valid   = r_held_valid;
        n_xor          = r_xor;
        n_frame_seq    = r_frame_seq;
        n_expected_seq = r_expected_seq;
        n_data_seen    = r_data_seen;
        n_emit         = 1'b0;
        n_res          = '0;

        case (r_state)
            ST_ADDR: begin
                if (i_byte == i_cfg.address_byte) begin
                    n_state = ST_CTRL;
                end else begin
                    n_state = (i_byte == i_cfg.flag_byte) ? ST_ADDR : ST_HUNT;
                end
            end
            ST_CTRL: begin
                if (i_byte == i_cfg.info_control_seq0) begin
                    n_frame_seq = 1'b0;
                    n_state     = ST_HCHK;
                end else if (i_byte == i_cfg.info_control_seq1) begin
                    n_frame_seq = 1'b1;
                    n_state     = ST_HCHK;
                end else begin
                    n_state = (i_byte == i_cfg.flag_byte) ? ST_ADDR : ST_HUNT;
                end
            end
            ST_HCHK: begin
                if (i_byte == (i_cfg.address_byte ^ ctrl)) begin
                    n_state      = ST_DATA;
                    n_held_valid = 1'b0;
                    n_xor        = '0;
                    n_data_seen  = 1'b0;
                end else begin
                    n_state = ST_HUNT;
                end
            end
            ST_DATA: begin
                if (i_byte == i_cfg.flag_byte) begin
                    // Closing flag: the held byte is the check byte.
                    n_state = ST_HUNT;
                    n_emit  = 1'b1;
                    ok      = r_held_valid && r_data_seen && (r_xor == r_held);
                    n_res.item_kind    = sfr_pkg::KIND_END;
                    n_res.reply_wanted = 1'b1;
                    n_res.reply_seq    = ~r_frame_seq;
                    if (!ok) begin
                        n_res.verdict         = sfr_pkg::VERDICT_CHECK_ERR;
                        n_res.reply_is_reject = 1'b1;
                    end else if (r_frame_seq == r_expected_seq) begin
                        n_res.verdict  = sfr_pkg::VERDICT_NEW;
                        n_expected_seq = ~r_expected_seq;
                    end else begin
                        n_res.verdict = sfr_pkg::VERDICT_DUPLICATE;
                    end
                end else if (i_byte == i_cfg.escape_byte) begin
                    n_state = ST_ESC;
                end else begin
                    take = 1'b1;
                end
            end
            ST_ESC: begin
                if (i_byte == i_cfg.escaped_flag_code) begin
                    n_state = ST_DATA;
                    take    = 1'b1;
                    data    = i_cfg.flag_byte;
                end else if (i_byte == i_cfg.escaped_escape_code) begin
                    n_state = ST_DATA;
                    take    = 1'b1;
                    data    = i_cfg.escape_byte;
                end else begin
                    n_state         = ST_HUNT;
                    n_emit          = 1'b1;
                    n_res.item_kind = sfr_pkg::KIND_END;
                    n_res.verdict   = sfr_pkg::VERDICT_BAD_ESC;
                end
            end
            default: begin
                n_state = (i_byte == i_cfg.flag_byte) ? ST_ADDR : ST_HUNT;
            end
        endcase

        // A data byte releases the one held before it.
        if (take) begin
            if (r_held_valid) begin
                n_emit             = 1'b1;
                n_res.item_kind    = sfr_pkg::KIND_PAYLOAD;
                n_res.payload_byte = r_held;
                n_xor              = r_xor ^ r_held;
                n_data_seen        = 1'b1;
            end
            n_held       = data;
            n_held_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_HUNT;
            r_held_valid   <= 1'b0;
            r_xor          <= '0;
            r_frame_seq    <= 1'b0;
            r_expected_seq <= 1'b0;
            r_data_seen    <= 1'b0;
            r_res_valid    <= 1'b0;
        end else begin
            if (w_proc) begin
                r_state        <= n_state;
                r_held_valid   <= n_held_valid;
                r_xor          <= n_xor;
                r_frame_seq    <= n_frame_seq;
                r_expected_seq <= n_expected_seq;
                r_data_seen    <= n_data_seen;
                r_res_valid    <= n_emit;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
        if (w_proc) begin
            r_held <= n_held;
            if (n_emit) begin
                r_res <= n_res;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

// ===== src/stuffed_frame_receiver.sv =====
// Byte-stuffed frame receiver with stop-and-wait sequencing. Each request on
// i_rx carries one received line byte; the block hunts for a flag, the
// configured address, one of the two information control codes (which give
// the frame's sequence bit) and a header check equal to address XOR control.
// The data field is destuffed (escape followed by the escaped-flag or
// escaped-escape code) and each data byte leaves on o_res one byte late, so
// the trailing check byte is never passed on. The closing flag produces one
// end-of-frame request with the verdict (new frame, duplicate, check error)
// and the RR or REJ reply to send, carrying the inverse of the frame's
// sequence bit; an unknown code after an escape ends the frame with a
// bad-escape verdict and no reply. After any end request the receiver hunts
// again, and the closing flag does not open the next frame. The block
// accepts one byte per clock cycle; a byte is registered on acceptance,
// parsed in the next cycle and its result, if any, sits in the output
// register from the cycle after that. When the consumer holds off the
// output register, the input register fills and i_rx.ready drops until
// the pending result is taken. Configuration registers are written
// through i_cfg_we / i_cfg_idx / i_cfg_data and must only be changed
// while no frame is in flight.
module stuffed_frame_receiver (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sfr_rx_if.sink                        i_rx,
    sfr_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_data
);

    sfr_pkg::t_cfg    w_cfg;
    sfr_pkg::t_result w_res;
    logic             w_parse_ready;

    // Input register: holds one accepted byte until the parser takes it.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_in_ready;

    assign w_in_ready = !r_in_valid || w_parse_ready;
    assign i_rx.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (w_in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    sfr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    sfr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_valid     (r_in_valid),
        .i_byte      (r_in_byte),
        .o_ready     (w_parse_ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .o_res       (w_res)
    );

    assign o_res.item_kind       = w_res.item_kind;
    assign o_res.payload_byte    = w_res.payload_byte;
    assign o_res.verdict         = w_res.verdict;
    assign o_res.reply_wanted    = w_res.reply_wanted;
    assign o_res.reply_is_reject = w_res.reply_is_reject;
    assign o_res.reply_seq       = w_res.reply_seq;

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

typedef logic [7:0] t_byte_q [$];

// Receiver parse phases, in the order a frame walks through them.
typedef enum logic [2:0] {
    ST_HUNT,
    ST_ADDR,
    ST_CTRL,
    ST_HCS,
    ST_DATA,
    ST_ESC
} t_parse_state;

class frame_scoreboard;
    sfr_pkg::t_cfg    cfg;
    t_parse_state     state;
    logic [7:0]       held_byte;
    bit               held_valid;
    logic [7:0]       running_xor;
    bit               frame_seq;
    bit               expected_seq;
    bit               data_seen;
    sfr_pkg::t_result expected_items[$];
    int               mismatches;

    function new();
        cfg = '{sfr_pkg::RST_FLAG, sfr_pkg::RST_ADDRESS, sfr_pkg::RST_ESCAPE,
                sfr_pkg::RST_ESC_FLAG, sfr_pkg::RST_ESC_ESCAPE,
                sfr_pkg::RST_CTRL_SEQ0, sfr_pkg::RST_CTRL_SEQ1};
        state        = ST_HUNT;
        held_byte    = 8'h00;
        held_valid   = 1'b0;
        running_xor  = 8'h00;
        frame_seq    = 1'b0;
        expected_seq = 1'b0;
        data_seen    = 1'b0;
        mismatches   = 0;
    endfunction

    function void set_register(logic [sfr_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
        case (idx)
            sfr_pkg::CFG_FLAG:       cfg.flag_byte = value;
            sfr_pkg::CFG_ADDRESS:    cfg.address_byte = value;
            sfr_pkg::CFG_ESCAPE:     cfg.escape_byte = value;
            sfr_pkg::CFG_ESC_FLAG:   cfg.escaped_flag_code = value;
            sfr_pkg::CFG_ESC_ESCAPE: cfg.escaped_escape_code = value;
            sfr_pkg::CFG_CTRL_SEQ0:  cfg.info_control_seq0 = value;
            sfr_pkg::CFG_CTRL_SEQ1:  cfg.info_control_seq1 = value;
            default: ;
        endcase
    endfunction

    function void post_item(logic kind, logic [7:0] pay, logic [1:0] verd,
                            logic want, logic rej, logic seq);
        sfr_pkg::t_result r;
        r.item_kind       = kind;
        r.payload_byte    = pay;
        r.verdict         = verd;
        r.reply_wanted    = want;
        r.reply_is_reject = rej;
        r.reply_seq       = seq;
        expected_items.push_back(r);
    endfunction

    // A new data byte pushes out the one held back before it.
    function void accept_data(logic [7:0] d);
        if (held_valid) begin
            post_item(sfr_pkg::KIND_PAYLOAD, held_byte, sfr_pkg::VERDICT_NEW,
                      1'b0, 1'b0, 1'b0);
            running_xor = running_xor ^ held_byte;
            data_seen   = 1'b1;
        end
        held_byte  = d;
        held_valid = 1'b1;
    endfunction

    function void parse_rx_byte(logic [7:0] c);
        logic [7:0] ctrl;
        case (state)
            ST_ADDR: begin
                if (c == cfg.address_byte) state = ST_CTRL;
                else state = (c == cfg.flag_byte) ? ST_ADDR : ST_HUNT;
            end
            ST_CTRL: begin
                if (c == cfg.info_control_seq0) begin
                    frame_seq = 1'b0;
                    state = ST_HCS;
                end else if (c == cfg.info_control_seq1) begin
                    frame_seq = 1'b1;
                    state = ST_HCS;
                end else begin
                    state = (c == cfg.flag_byte) ? ST_ADDR : ST_HUNT;
                end
            end
            ST_HCS: begin
                ctrl = frame_seq ? cfg.info_control_seq1 : cfg.info_control_seq0;
                if (c == (cfg.address_byte ^ ctrl)) begin
                    state       = ST_DATA;
                    held_valid  = 1'b0;
                    running_xor = 8'h00;
                    data_seen   = 1'b0;
                end else begin
                    state = ST_HUNT;
                end
            end
            ST_DATA: begin
                if (c == cfg.flag_byte) begin
                    state = ST_HUNT;
                    if (held_valid && data_seen && running_xor == held_byte) begin
                        if (frame_seq == expected_seq) begin
                            post_item(sfr_pkg::KIND_END, 8'h00, sfr_pkg::VERDICT_NEW,
                                      1'b1, 1'b0, ~frame_seq);
                            expected_seq = ~expected_seq;
                        end else begin
                            post_item(sfr_pkg::KIND_END, 8'h00, sfr_pkg::VERDICT_DUPLICATE,
                                      1'b1, 1'b0, ~frame_seq);
                        end
                    end else begin
                        post_item(sfr_pkg::KIND_END, 8'h00, sfr_pkg::VERDICT_CHECK_ERR,
                                  1'b1, 1'b1, ~frame_seq);
                    end
                end else if (c == cfg.escape_byte) begin
                    state = ST_ESC;
                end else begin
                    accept_data(c);
                end
            end
            ST_ESC: begin
                if (c == cfg.escaped_flag_code) begin
                    state = ST_DATA;
                    accept_data(cfg.flag_byte);
                end else if (c == cfg.escaped_escape_code) begin
                    state = ST_DATA;
                    accept_data(cfg.escape_byte);
                end else begin
                    state = ST_HUNT;
                    post_item(sfr_pkg::KIND_END, 8'h00, sfr_pkg::VERDICT_BAD_ESC,
                              1'b0, 1'b0, 1'b0);
                end
            end
            default: state = (c == cfg.flag_byte) ? ST_ADDR : ST_HUNT;
        endcase
    endfunction

    task report_mismatch(string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task check_item(sfr_pkg::t_result got);
        sfr_pkg::t_result want;
        string            bad;
        if (expected_items.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with nothing pending", got));
            return;
        end
        want = expected_items.pop_front();
        bad = "";
        if (got.item_kind !== want.item_kind) bad = {bad, " item_kind"};
        if (got.payload_byte !== want.payload_byte) bad = {bad, " payload_byte"};
        if (got.verdict !== want.verdict) bad = {bad, " verdict"};
        if (got.reply_wanted !== want.reply_wanted) bad = {bad, " reply_wanted"};
        if (got.reply_is_reject !== want.reply_is_reject) bad = {bad, " reply_is_reject"};
        if (got.reply_seq !== want.reply_seq) bad = {bad, " reply_seq"};
        if (bad != "")
            report_mismatch($sformatf("wrong%s: got %h, wanted %h", bad, got, want));
    endtask
endclass

module testbench;

    // Writes to an index past the register list must be ignored by the block.
    localparam logic [sfr_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;
    localparam int PHASES          = 8;
    localparam int BYTES_PER_PHASE = 135;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [sfr_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [7:0]                    i_cfg_data;

    sfr_rx_if  rx_ch ();
    sfr_res_if res_ch ();

    t_idle_mode      idle_mode = IDLE_NONE;
    frame_scoreboard sb;
    int              bytes_sent;

    stuffed_frame_receiver dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (rx_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The result consumer. Ready changes only at the falling edge, so the block
    // sees a settled value at every rising edge. The stall rate follows the
    // current idling phase.
    always @(negedge i_clk) begin
        case (idle_mode)
            IDLE_RECEIVER: res_ch.ready <= ($urandom_range(99) >= 53);
            IDLE_BOTH:     res_ch.ready <= ($urandom_range(99) >= 28);
            default:       res_ch.ready <= 1'b1;
        endcase
    end

    // Every result request taken at a rising edge is compared with the oldest
    // prediction. The outputs are read before any update of this edge lands.
    always @(posedge i_clk) begin
        sfr_pkg::t_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.item_kind       = res_ch.item_kind;
            got.payload_byte    = res_ch.payload_byte;
            got.verdict         = res_ch.verdict;
            got.reply_wanted    = res_ch.reply_wanted;
            got.reply_is_reject = res_ch.reply_is_reject;
            got.reply_seq       = res_ch.reply_seq;
            sb.check_item(got);
        end
    end

    // Offers one line byte, possibly after some idle cycles, and waits until
    // the block takes it. Called and left at a falling edge; valid stays high
    // on return so that back-to-back bytes need no extra cycle.
    task automatic send_byte(input logic [7:0] b);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 53 : (idle_mode == IDLE_BOTH) ? 28 : 0;
        while ($urandom_range(99) < pct) begin
            rx_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   = 1'b1;
        rx_ch.rx_byte = b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        sb.parse_rx_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits for every predicted result. A byte that causes
    // no result may still be inside the block, so the task waits on after
    // the last predicted result has arrived.
    task automatic drain_results();
        rx_ch.valid = 1'b0;
        while (sb.expected_items.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [sfr_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [7:0] value);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = value;
        @(posedge i_clk);
        sb.set_register(idx, value);
        @(negedge i_clk);
    endtask

    task automatic load_config(input sfr_pkg::t_cfg c);
        write_register(sfr_pkg::CFG_FLAG, c.flag_byte);
        write_register(sfr_pkg::CFG_ADDRESS, c.address_byte);
        write_register(sfr_pkg::CFG_ESCAPE, c.escape_byte);
        write_register(sfr_pkg::CFG_ESC_FLAG, c.escaped_flag_code);
        write_register(sfr_pkg::CFG_ESC_ESCAPE, c.escaped_escape_code);
        write_register(sfr_pkg::CFG_CTRL_SEQ0, c.info_control_seq0);
        write_register(sfr_pkg::CFG_CTRL_SEQ1, c.info_control_seq1);
        write_register(CFG_SPARE_IDX, 8'($urandom_range(255)));
        i_cfg_we = 1'b0;
    endtask

    // Register settings per phase: reset values, all-extreme values, flag
    // equal to escape, equal control codes together with equal escape codes,
    // and a fully random set.
    function automatic sfr_pkg::t_cfg config_set(input int k);
        sfr_pkg::t_cfg c;
        case (k)
            1: c = '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
            2: c = '{8'hA5, 8'h5A, 8'hA5, 8'h01, 8'h02, 8'h10, 8'h11};
            3: c = '{8'hFF, 8'h00, 8'h80, 8'h44, 8'h44, 8'h77, 8'h77};
            4: c = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom)};
            default: c = '{sfr_pkg::RST_FLAG, sfr_pkg::RST_ADDRESS, sfr_pkg::RST_ESCAPE,
                           sfr_pkg::RST_ESC_FLAG, sfr_pkg::RST_ESC_ESCAPE,
                           sfr_pkg::RST_CTRL_SEQ0, sfr_pkg::RST_CTRL_SEQ1};
        endcase
        return c;
    endfunction

    // Flag, address, control code for the given sequence bit and header check.
    function automatic t_byte_q frame_head(input bit seq);
        t_byte_q    h;
        logic [7:0] ctrl;
        ctrl = seq ? sb.cfg.info_control_seq1 : sb.cfg.info_control_seq0;
        h = '{sb.cfg.flag_byte, sb.cfg.address_byte, ctrl, sb.cfg.address_byte ^ ctrl};
        return h;
    endfunction

    // A byte that is neither escape code, so it breaks an escaped pair.
    function automatic logic [7:0] bad_code();
        logic [7:0] b;
        do b = 8'($urandom_range(255));
        while (b == sb.cfg.escaped_flag_code || b == sb.cfg.escaped_escape_code);
        return b;
    endfunction

    // Picks a byte that sends the parser straight back to hunting: a
    // closing flag inside the data field, a broken pair after an escape, and
    // a non-matching byte in the header states.
    function automatic logic [7:0] hunt_byte();
        logic [7:0] b;
        logic [7:0] ctrl;
        ctrl = sb.frame_seq ? sb.cfg.info_control_seq1 : sb.cfg.info_control_seq0;
        case (sb.state)
            ST_DATA: b = sb.cfg.flag_byte;
            ST_ESC:  b = bad_code();
            ST_ADDR: do b = 8'($urandom_range(255));
                     while (b == sb.cfg.address_byte || b == sb.cfg.flag_byte);
            ST_CTRL: do b = 8'($urandom_range(255));
                     while (b == sb.cfg.info_control_seq0 || b == sb.cfg.info_control_seq1 ||
                            b == sb.cfg.flag_byte);
            ST_HCS:  do b = 8'($urandom_range(255));
                     while (b == (sb.cfg.address_byte ^ ctrl));
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    task automatic flush_to_hunt();
        while (sb.state != ST_HUNT) send_byte(hunt_byte());
    endtask

    // Sends a frame: the given head, the data field with its XOR check byte
    // appended and stuffed, and the closing flag. A corrupted check byte, a
    // broken escape at position bad_at (which ends the frame there) and a
    // missing closing flag are selectable.
    task automatic send_frame(input t_byte_q head, input t_byte_q data, input bit chk_ok,
                              input int bad_at, input bit close);
        t_byte_q    line;
        logic [7:0] chk;
        chk  = 8'h00;
        line = head;
        foreach (data[i]) chk = chk ^ data[i];
        if (!chk_ok) chk = chk ^ 8'($urandom_range(255, 1));
        data.push_back(chk);
        for (int i = 0; i < data.size(); i++) begin
            if (i == bad_at) begin
                line.push_back(sb.cfg.escape_byte);
                line.push_back(bad_code());
                close = 1'b0;
                break;
            end
            if (data[i] == sb.cfg.flag_byte) begin
                line.push_back(sb.cfg.escape_byte);
                line.push_back(sb.cfg.escaped_flag_code);
            end else if (data[i] == sb.cfg.escape_byte) begin
                line.push_back(sb.cfg.escape_byte);
                line.push_back(sb.cfg.escaped_escape_code);
            end else begin
                line.push_back(data[i]);
            end
        end
        if (close) line.push_back(sb.cfg.flag_byte);
        foreach (line[i]) send_byte(line[i]);
    endtask

    // Mostly well-formed frames with the expected sequence bit and random
    // content rich in flag and escape values; the rest carries line noise,
    // duplicates, header faults, bad checks, broken escapes and lost flags.
    task automatic send_random_frame();
        t_byte_q head;
        t_byte_q data;
        int      n;
        int      r;
        bit      seq;
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
        seq  = ($urandom_range(99) < 85) ? sb.expected_seq : ~sb.expected_seq;
        head = frame_head(seq);
        r = $urandom_range(99);
        if (r < 4) head[1] = head[1] ^ 8'($urandom_range(255, 1));
        else if (r < 8) head[2] = 8'($urandom_range(255));
        else if (r < 12) head[3] = head[3] ^ 8'($urandom_range(255, 1));
        r = $urandom_range(99);
        n = (r < 10) ? 0 : (r < 80) ? $urandom_range(6, 1) : $urandom_range(16, 7);
        repeat (n) begin
            case ($urandom_range(7))
                0:       data.push_back(sb.cfg.flag_byte);
                1:       data.push_back(sb.cfg.escape_byte);
                default: data.push_back(8'($urandom_range(255)));
            endcase
        end
        send_frame(head, data, $urandom_range(99) >= 10,
                   ($urandom_range(99) < 6) ? int'($urandom_range(n)) : -1,
                   $urandom_range(99) >= 4);
    endtask

    initial begin
        t_byte_q q;
        int      phase_start;
        sb            = new();
        bytes_sent    = 0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = sfr_pkg::CFG_FLAG;
        i_cfg_data    = 8'h00;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames at the reset settings: a good frame whose data holds
        // both extremes plus a literal flag and a literal escape, a frame with
        // an empty data field, and a frame cut short by a broken escape.
        q = '{8'h00, 8'hFF, sfr_pkg::RST_FLAG, sfr_pkg::RST_ESCAPE};
        send_frame(frame_head(1'b0), q, 1'b1, -1, 1'b1);
        q.delete();
        send_frame(frame_head(1'b1), q, 1'b1, -1, 1'b1);
        send_frame(frame_head(1'b1), q, 1'b1, 0, 1'b1);

        // Random phases. Each starts from an idle block: the parser is walked
        // back to hunting, all results are collected, and then every register
        // is rewritten. The idling pattern rotates with the phase.
        for (int p = 0; p < PHASES; p++) begin
            flush_to_hunt();
            drain_results();
            load_config(config_set(p % 6));
            idle_mode = t_idle_mode'(p % 4);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
                send_random_frame();
                // Now and then the sender holds off until the block is empty.
                if ($urandom_range(49) == 0) drain_results();
            end
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.expected_items.size() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived",
                                         sb.expected_items.size()));
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
